FILE: design/utf8_stream_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// utf8 stream decoder assertion macros
// shared property wrappers, clocked and gated by the synchronous reset
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define U8D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u8d assertion failed");

// next-cycle implication
`define U8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u8d assertion failed");

`endif

FILE: design/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// shared types, constants and decode helpers of the utf8 stream decoder
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned JobDepthDefault = 4;
    localparam int unsigned CpWidth         = 21;

    // one parse job: up to four raw bytes, byte 0 in the low lane
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      total;
        logic            last;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_req;

    // sequence length from the lead byte
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        if ((b & 8'hf8) == 8'hf0) begin
            len = 3'd4;
        end else if ((b & 8'hf0) == 8'he0) begin
            len = 3'd3;
        end else if ((b & 8'he0) == 8'hc0) begin
            len = 3'd2;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    // assemble a code point from len bytes starting at lane 0
    function automatic logic [CpWidth-1:0] decode_seq(input logic [3:0][7:0] b,
                                                      input logic [2:0]      len);
        logic [CpWidth-1:0] cp;
        unique case (len)
            3'd2:    cp = {10'd0, b[0][4:0], b[1][5:0]};
            3'd3:    cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
            3'd4:    cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
            default: cp = {14'd0, b[0][6:0]};
        endcase
        return cp;
    endfunction

endpackage

FILE: design/u8d_fifo.sv
// ----------------------------------------------------------------------------
// u8d_fifo
// short job queue between the byte front end and the result back end
// ----------------------------------------------------------------------------
module u8d_fifo
    import u8d_pkg::*;
#(
    parameter int unsigned DEPTH = JobDepthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job_req i_wr,
    input  logic i_rd,
    output t_job o_rdata,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            wr_en, rd_en;

    assign wr_en   = i_wr.valid && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr.job;
        end
    end

endmodule

FILE: design/u8d_front.sv
// ----------------------------------------------------------------------------
// u8d_front
// takes raw bytes, holds an unfinished sequence, hands out parse jobs
// ----------------------------------------------------------------------------
module u8d_front
    import u8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  logic [7:0] i_in_byte,
    input  logic     i_is_last,
    output t_job_req o_job
);

    logic [7:0] r_pend [3];
    logic [1:0] r_cnt, n_cnt;
    logic [3:0][7:0] buf_bytes;
    logic [2:0] total;
    logic [2:0] need;
    logic       emit;

    // held bytes followed by the new one, unused lanes zero
    always_comb begin
        buf_bytes = '0;
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < r_cnt) begin
                buf_bytes[k] = r_pend[2'(k)];
            end
        end
        buf_bytes[r_cnt] = i_in_byte;
    end

    assign total = {1'b0, r_cnt} + 3'd1;
    assign need  = seq_len(buf_bytes[0]);
    // sequence complete, or text ends and the back end reparses
    assign emit  = (total >= need) || i_is_last;

    assign o_job.valid     = i_accept && emit;
    assign o_job.job.bytes = buf_bytes;
    assign o_job.job.total = total;
    assign o_job.job.last  = i_is_last;

    always_comb begin
        n_cnt = r_cnt;
        if (i_accept) begin
            n_cnt = emit ? 2'd0 : total[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !emit) begin
            r_pend[r_cnt] <= i_in_byte;
        end
    end

endmodule

FILE: design/u8d_back.sv
// ----------------------------------------------------------------------------
// u8d_back
// parses one job into code points, one per cycle while the result register is free or popped, into the result register
// ----------------------------------------------------------------------------
module u8d_back
    import u8d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_avail,
    input  t_job i_job,
    output logic o_job_rd,
    input  logic i_pop,
    output logic o_valid,
    output logic [CpWidth-1:0] o_code_point,
    output logic [2:0] o_byte_count,
    output logic o_last_of_run,
    output logic o_end_of_text
);

    logic            r_busy, n_busy;
    logic [3:0][7:0] r_bytes, n_bytes;
    logic [2:0]      r_rem, n_rem;
    logic            r_last, n_last;
    logic            r_valid, n_valid;
    logic [CpWidth-1:0] r_cp;
    logic [2:0]      r_cnt;
    logic            r_lor, r_eot;

    logic       pop_ok;
    logic       adv;
    logic [2:0] lead_len;
    logic [2:0] len;
    logic       fin;
    logic       load;

    assign pop_ok   = i_pop && r_valid;
    assign adv      = r_busy && (!r_valid || pop_ok);
    assign lead_len = seq_len(r_bytes[0]);
    // a lead that does not fit in what remains counts as a single byte
    assign len      = (lead_len > r_rem) ? 3'd1 : lead_len;
    assign fin      = (len == r_rem);
    assign load     = i_job_avail && (!r_busy || (adv && fin));
    assign o_job_rd = load;

    always_comb begin
        n_busy  = r_busy;
        n_bytes = r_bytes;
        n_rem   = r_rem;
        n_last  = r_last;
        n_valid = r_valid;
        if (pop_ok) begin
            n_valid = 1'b0;
        end
        if (adv) begin
            n_valid = 1'b1;
            n_rem   = r_rem - len;
            n_bytes = r_bytes >> {len, 3'b000};
            if (fin) begin
                n_busy = 1'b0;
            end
        end
        if (load) begin
            n_busy  = 1'b1;
            n_bytes = i_job.bytes;
            n_rem   = i_job.total;
            n_last  = i_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_rem   <= n_rem;
        r_last  <= n_last;
        if (adv) begin
            r_cp  <= decode_seq(r_bytes, len);
            r_cnt <= len;
            r_lor <= fin;
            r_eot <= fin && r_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_code_point  = r_cp;
    assign o_byte_count  = r_cnt;
    assign o_last_of_run = r_lor;
    assign o_end_of_text = r_eot;

endmodule

FILE: design/utf8_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// utf8 byte stream in, one code point per sequence out
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | beat payload
//  ---------+----------------------+------------------------------------------
//  input    | push / full          | in_byte, is_last
//  result   | pop / empty          | code_point, byte_count, last_of_run,
//           |                      | end_of_text
//
//  one input beat per cycle while the queue has room; a byte that completes
//  a sequence is queued as a job, loaded into the back end and decoded into
//  the result register; one result per cycle while results are popped, so
//  an unfinished sequence flushed at end of text yields up to three results;
//  the job queue absorbs it while the input keeps flowing until it fills
//  reset is synchronous active low and empties the queue, result register
//  and held-byte count; full rises only when the job queue is full
//
`include "utf8_stream_decoder_core_assert.svh"

module utf8_stream_decoder_core
    import u8d_pkg::*;
#(
    parameter int unsigned JOB_DEPTH = JobDepthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_last,
    // result output
    output logic       empty,
    input  logic       pop,
    output logic [CpWidth-1:0] o_code_point,
    output logic [2:0] o_byte_count,
    output logic       o_last_of_run,
    output logic       o_end_of_text
);

    t_job_req front_job;   // job handed from front end to the queue
    t_job     q_head;      // oldest queued job
    logic     q_full;
    logic     q_empty;
    logic     q_rd;
    logic     in_accept;
    logic     res_valid;

    // input beat taken whenever the queue has room
    assign full      = q_full;
    assign in_accept = push && !q_full;

    // front: keeps bytes of an unfinished sequence, emits a job when one
    // completes or the text ends
    u8d_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_in_byte (i_in_byte),
        .i_is_last (i_is_last),
        .o_job     (front_job)
    );

    // decoupling queue between classification and decode
    u8d_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_job),
        .i_rd    (q_rd),
        .o_rdata (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: walks each job, one code point per cycle into the result register while it is free or popped
    u8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_avail   (!q_empty),
        .i_job         (q_head),
        .o_job_rd      (q_rd),
        .i_pop         (pop),
        .o_valid       (res_valid),
        .o_code_point  (o_code_point),
        .o_byte_count  (o_byte_count),
        .o_last_of_run (o_last_of_run),
        .o_end_of_text (o_end_of_text)
    );

    assign empty = !res_valid;

    // end of text is only ever flagged on the closing result of a byte
    `U8D_ASSERT_NOW(a_eot_closes_run, i_clk, i_rst_n, !empty && o_end_of_text, o_last_of_run)
    // queue occupancy is consistent
    `U8D_ASSERT_NOW(a_queue_sane, i_clk, i_rst_n, 1'b1, !(q_full && q_empty))
    // results of one byte follow each other with no gap
    `U8D_ASSERT_NEXT(a_run_no_gap, i_clk, i_rst_n, !empty && pop && !o_last_of_run, !empty)
    // every result covers one to four bytes
    `U8D_ASSERT_NOW(a_count_range, i_clk, i_rst_n, !empty, o_byte_count - 3'd1 <= 3'd3)

endmodule

FILE: bench/utf8_stream_decoder_checker.sv
// ----------------------------------------------------------------------------
// utf8 stream decoder checker
// watches both channels, predicts code points from accepted bytes and
// compares every popped result with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_decoder_checker
    import u8d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [7:0]         i_in_byte,
    input  logic               i_is_last,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic [CpWidth-1:0] i_code_point,
    input  logic [2:0]         i_byte_count,
    input  logic               i_last_of_run,
    input  logic               i_end_of_text,
    output int                 o_outstanding,
    output int                 o_fail_count,
    output int                 o_result_count
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic [2:0]         byte_count;
        logic               last_of_run;
        logic               end_of_text;
    } t_cp_beat;

    t_cp_beat        expected_cps[$];
    logic [2:0][7:0] held_bytes;
    int unsigned     held_count;
    int              fails;
    int              results;

    function automatic int unsigned lead_length(input logic [7:0] b);
        if ((b & 8'hf8) == 8'hf0) return 4;
        if ((b & 8'hf0) == 8'he0) return 3;
        if ((b & 8'he0) == 8'hc0) return 2;
        return 1;
    endfunction

    function automatic logic [CpWidth-1:0] assemble(input logic [3:0][7:0] seq,
                                                   input int unsigned     pos,
                                                   input int unsigned     len);
        logic [31:0] acc;
        int unsigned k;
        if (len == 1) acc = 32'(seq[pos] & 8'h7f);
        else          acc = 32'(seq[pos]) & ((32'd1 << (7 - len)) - 1);
        for (k = 1; k < len; k++) acc = (acc << 6) | 32'(seq[pos + k] & 8'h3f);
        return acc[CpWidth-1:0];
    endfunction

    task automatic predict_code_points(input logic [7:0] b, input logic last);
        logic [3:0][7:0] seq;
        t_cp_beat        beat [3];
        int unsigned     n, pos, len, made, k;
        seq  = '0;
        made = 0;
        for (k = 0; k < held_count; k++) seq[k] = held_bytes[k];
        seq[held_count] = b;
        n = held_count + 1;
        if (n >= lead_length(seq[0])) begin
            len            = lead_length(seq[0]);
            beat[0]        = '0;
            beat[0].code_point = assemble(seq, 0, len);
            beat[0].byte_count = 3'(len);
            made       = 1;
            held_count = 0;
        end else if (!last) begin
            // sequence still open, hold the byte
            for (k = 0; k < n; k++) held_bytes[k] = seq[k];
            held_count = n;
        end else begin
            // text ended mid-sequence: reparse the held bytes from the front
            pos = 0;
            while (pos < n && made < 3) begin
                len = lead_length(seq[pos]);
                if (pos + len > n) len = 1;
                beat[made]            = '0;
                beat[made].code_point = assemble(seq, pos, len);
                beat[made].byte_count = 3'(len);
                made++;
                pos += len;
            end
            held_count = 0;
        end
        for (k = 0; k < made; k++) begin
            beat[k].last_of_run = (k == made - 1);
            beat[k].end_of_text = (k == made - 1) && last;
            expected_cps = {expected_cps, beat[k]};
        end
    endtask

    task automatic note_failure(input string msg);
        fails++;
        if (fails <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
    endtask

    task automatic check_code_point();
        t_cp_beat want, got;
        got = {i_code_point, i_byte_count, i_last_of_run, i_end_of_text};
        results++;
        if (expected_cps.size() == 0) begin
            note_failure($sformatf("unexpected result cp=%06h cnt=%0d last=%0b eot=%0b",
                                   got.code_point, got.byte_count,
                                   got.last_of_run, got.end_of_text));
        end else begin
            want = expected_cps.pop_front();
            if (got !== want)
                note_failure($sformatf({"mismatch exp cp=%06h cnt=%0d last=%0b eot=%0b",
                                        " got cp=%06h cnt=%0d last=%0b eot=%0b"},
                                       want.code_point, want.byte_count,
                                       want.last_of_run, want.end_of_text,
                                       got.code_point, got.byte_count,
                                       got.last_of_run, got.end_of_text));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            expected_cps.delete();
            o_outstanding <= 0;
        end else begin
            if (i_push && !i_full) predict_code_points(i_in_byte, i_is_last);
            if (i_pop && !i_empty) check_code_point();
            o_outstanding <= expected_cps.size();
        end
        o_fail_count   <= fails;
        o_result_count <= results;
    end

endmodule

FILE: bench/tb_utf8_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8 stream decoder core testbench
// directed and random byte texts pushed under varying idle and stall mixes,
// with results checked beat by beat by the checker beside the core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_core;
    import u8d_pkg::*;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int RESET_CYCLES      = 7;
    localparam int HOLD_CYCLES       = 80;    // long receiver hold-off
    localparam int PHASE_BYTES       = 12;    // random bytes per idle mix
    localparam int PRESSURE_BYTES    = 16;
    localparam int END_SETTLE_CYCLES = 20;    // settle time before the final report
    localparam int NUM_DIRECTED      = 26;

    // directed beats: {is_last, byte}
    localparam logic [8:0] DIRECTED_BEATS [NUM_DIRECTED] = '{
        {1'b0, 8'h00},                                  // lowest ascii
        {1'b0, 8'h7f},                                  // highest ascii
        {1'b0, 8'h80},                                  // stray continuation as lead
        {1'b0, 8'hff},                                  // invalid lead, single byte
        {1'b0, 8'hc2}, {1'b0, 8'ha9},                   // two-byte sequence
        {1'b0, 8'he2}, {1'b0, 8'h82}, {1'b0, 8'hac},    // three-byte sequence
        {1'b0, 8'hf0}, {1'b0, 8'h9f}, {1'b0, 8'h98}, {1'b0, 8'h80},
        {1'b0, 8'hf7}, {1'b0, 8'hbf}, {1'b0, 8'hbf},    // largest code point,
        {1'b1, 8'hbf},                                  // closing the text
        {1'b0, 8'hc3}, {1'b0, 8'h41},                   // continuation not checked
        {1'b0, 8'hf0}, {1'b0, 8'h41}, {1'b1, 8'h42},    // cut short: three singles
        {1'b0, 8'he2}, {1'b0, 8'hc3}, {1'b1, 8'ha9},    // lead fits: one three-byte sequence
        {1'b1, 8'hc3}                                   // lone lead ends the text
    };

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push    = 1'b0;
    logic               full;
    logic [7:0]         in_byte = 8'h00;
    logic               is_last = 1'b0;
    logic               empty;
    logic               pop     = 1'b0;
    logic [CpWidth-1:0] code_point;
    logic [2:0]         byte_count;
    logic               last_of_run;
    logic               end_of_text;

    int outstanding, fail_count, result_count;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;         // bumped to ask the receiver for a long hold-off
    int bytes_sent = 0;
    int texts_sent = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    utf8_stream_decoder_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in_byte     (in_byte),
        .i_is_last     (is_last),
        .empty         (empty),
        .pop           (pop),
        .o_code_point  (code_point),
        .o_byte_count  (byte_count),
        .o_last_of_run (last_of_run),
        .o_end_of_text (end_of_text)
    );

    utf8_stream_decoder_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_in_byte      (in_byte),
        .i_is_last      (is_last),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_code_point   (code_point),
        .i_byte_count   (byte_count),
        .i_last_of_run  (last_of_run),
        .i_end_of_text  (end_of_text),
        .o_outstanding  (outstanding),
        .o_fail_count   (fail_count),
        .o_result_count (result_count)
    );

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_utf8_stream_decoder_core: FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    int hold_left = 0;
    int hold_seen = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // offer one byte beat, with a random gap in front of it; push stays high
    // afterwards so back-to-back beats never lower and raise it in one step
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        push    <= 1'b1;
        in_byte <= b;
        is_last <= last;
        do @(posedge i_clk); while (full);
        bytes_sent++;
        if (last) texts_sent++;
    endtask

    task automatic send_text(ref logic [7:0] text[$]);
        int k;
        for (k = 0; k < text.size(); k++) send_byte(text[k], k == text.size() - 1);
    endtask

    // mostly well-formed sequences, some noise bytes and cut-short sequences
    task automatic add_sequence(ref logic [7:0] text[$]);
        int unsigned kind, len, k;
        logic [31:0] rnd;
        kind = $urandom_range(99);
        rnd  = $urandom;
        if (kind < 15) begin
            text = {text, rnd[7:0]};
            return;
        end
        len = $urandom_range(1, 4);
        case (len)
            1:       text = {text, {1'b0, rnd[6:0]}};
            2:       text = {text, {3'b110, rnd[4:0]}};
            3:       text = {text, {4'b1110, rnd[3:0]}};
            default: text = {text, {5'b11110, rnd[2:0]}};
        endcase
        if (kind >= 85 && len > 1) len = $urandom_range(1, len - 1);
        for (k = 1; k < len; k++) begin
            rnd = $urandom;
            text = {text, {2'b10, rnd[5:0]}};
        end
    endtask

    // sender pauses until every predicted code point has been popped
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        logic [7:0] text[$];
        int         phase, phase_start, k, n_seq;
        int         tx_mix [4] = '{0, 87, 0, 20};
        int         rx_mix [4] = '{0, 0, 87, 20};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner cases, no idling
        for (k = 0; k < NUM_DIRECTED; k++)
            send_byte(DIRECTED_BEATS[k][7:0], DIRECTED_BEATS[k][8]);
        drain();

        for (phase = 0; phase < 4; phase++) begin
            tx_idle_pct  = tx_mix[phase];
            rx_stall_pct = rx_mix[phase];
            if (phase == 0) begin
                // receiver holds off while bytes keep coming, core must fill up
                hold_req <= hold_req + 1;
                text.delete();
                for (k = 0; k < PRESSURE_BYTES; k++)
                    text = {text, 8'($urandom_range(127))};
                send_text(text);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                text.delete();
                n_seq = $urandom_range(1, 6);
                for (k = 0; k < n_seq; k++) add_sequence(text);
                send_text(text);
            end
            drain();
        end

        repeat (END_SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d byte beats in %0d texts, %0d code points checked",
                 bytes_sent, texts_sent, result_count);
        $display("idle mixes: none, sender 87%%, receiver 87%%, both 20%%, long hold-off");
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_utf8_stream_decoder_core: PASS");
        end else begin
            $display("tb_utf8_stream_decoder_core: FAIL");
        end
        $finish;
    end

endmodule
